>>> design/cbfl_pkg.sv
// Shared constants and codes of the cluster and block free-list allocator.
`timescale 1ns / 1ps
package cbfl_pkg;

    // Default geometry; both per-node and per-cluster counts are powers of two.
    localparam int NODE_COUNT_DEF         = 16;
    localparam int CLUSTERS_PER_NODE_DEF  = 256;
    localparam int BLOCKS_PER_CLUSTER_DEF = 8;

    // Field widths of the stream payloads.
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int ADDR_W    = 15;
    localparam int COUNT_W   = 12;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // Request kinds.
    typedef logic [REQ_W-1:0] t_req;
    localparam t_req REQ_ALLOC_CLUSTER = 2'd0;
    localparam t_req REQ_FREE_CLUSTER  = 2'd1;
    localparam t_req REQ_ALLOC_BLOCK   = 2'd2;
    localparam t_req REQ_FREE_BLOCK    = 2'd3;

    // Result status codes.
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_NOSPACE = 2'd1;
    localparam t_status ST_BADFREE = 2'd2;
    localparam t_status ST_UNUSED  = 2'd3;

endpackage

>>> design/cluster_and_block_free_list_allocator_unit.sv
// Top level of the two-level cluster and block free-list allocator.
// A cluster release is done in the idle state and a cluster allocation reads the
// cluster stack. A block release reads the group depth and links the group behind
// a tail when it joins the list; a block allocation reads the head group, and when a
// new cluster is drawn, its block stack is filled first. Items are taken one at a
// time, a new one only in the idle state. After reset the cluster stack memory is
// formatted, during which no item is accepted.
`timescale 1ns / 1ps
module cluster_and_block_free_list_allocator_unit #(
    parameter int NODE_COUNT         = cbfl_pkg::NODE_COUNT_DEF,
    parameter int CLUSTERS_PER_NODE  = cbfl_pkg::CLUSTERS_PER_NODE_DEF,
    parameter int BLOCKS_PER_CLUSTER = cbfl_pkg::BLOCKS_PER_CLUSTER_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // release_address [14:0], zero padding [15]
    input  logic [cbfl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type [1:0]
    input  logic [cbfl_pkg::REQ_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // granted_address [14:0], free_cluster_count [26:15], zero padding [31:27]
    output logic [cbfl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic [cbfl_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import cbfl_pkg::*;

    localparam int TC  = NODE_COUNT * CLUSTERS_PER_NODE;
    localparam int TB  = TC * BLOCKS_PER_CLUSTER;
    localparam int NIW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int NW  = $clog2(NODE_COUNT + 1);
    localparam int OW  = $clog2(CLUSTERS_PER_NODE);
    localparam int BW  = $clog2(BLOCKS_PER_CLUSTER);
    localparam int CIW = $clog2(TC);
    localparam int GIW = $clog2(TC);
    localparam int GW  = $clog2(TC + 1);
    localparam int BIW = $clog2(TB);
    localparam int CW  = $clog2(TC + 1);
    localparam logic [NW-1:0] NODE_NULL  = NW'(NODE_COUNT);
    localparam logic [GW-1:0] GROUP_NULL = GW'(TC);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CRD    = 4'd2;
    localparam logic [3:0] S_FILL   = 4'd3;
    localparam logic [3:0] S_BRD1   = 4'd4;
    localparam logic [3:0] S_BRD2   = 4'd5;
    localparam logic [3:0] S_RBD    = 4'd6;
    localparam logic [3:0] S_RBLINK = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]     r_state;
    logic [CW-1:0]  r_clr;
    t_req           r_req;
    logic [NIW-1:0] r_h;
    logic [GIW-1:0] r_g;
    logic [BW-1:0]  r_fill;
    logic [BW-1:0]  r_d;
    logic [BW-1:0]  r_off;
    logic           r_ok;
    logic [GW-1:0]  r_nx;
    t_status        r_st;
    logic [ADDR_W-1:0] r_ga;

    // Node and block group list state.
    logic [OW-1:0]  r_cdep  [NODE_COUNT];
    logic [NW-1:0]  r_nnext [NODE_COUNT];
    logic [NW-1:0]  r_nhead;
    logic [NW-1:0]  r_ntail;
    logic [CW-1:0]  r_free;
    logic [GW-1:0]  r_bhead;
    logic [GW-1:0]  r_btail;

    // Output register.
    logic              r_o_valid;
    t_status           r_o_status;
    logic [ADDR_W-1:0] r_o_addr;
    logic [COUNT_W-1:0] r_o_free;

    // Memories and their registered read data.
    logic [OW-1:0] m_cstk [TC];
    logic [BW-1:0] m_bstk [TB];
    logic [BW-1:0] m_bdep [TC];
    logic [GW-1:0] m_bnext [TC];
    logic [OW-1:0] r_cs_q;
    logic [BW-1:0] r_bs_q;
    logic [BW-1:0] r_bd_q;
    logic [GW-1:0] r_bn_q;

    logic           cs_we, bs_we, bd_we, bn_we;
    logic [CIW-1:0] cs_wa, cs_ra;
    logic [OW-1:0]  cs_wd;
    logic [BIW-1:0] bs_wa, bs_ra;
    logic [BW-1:0]  bs_wd;
    logic [GIW-1:0] bd_wa, bd_ra;
    logic [BW-1:0]  bd_wd;
    logic [GIW-1:0] bn_wa, bn_ra;
    logic [GW-1:0]  bn_wd;

    // Decoding of the incoming request.
    logic [ADDR_W-1:0] w_a;
    logic [31:0]       w_clus;
    logic              w_in_range;
    logic [NIW-1:0]    w_rnode;
    logic [OW-1:0]     w_roff;
    logic [OW-1:0]     w_rdep;
    logic              w_rc_ok;
    logic              w_rc_link;
    logic [GIW-1:0]    w_rgrp;
    logic [NIW-1:0]    w_hidx;
    logic [OW-1:0]     w_hdep;
    logic [OW-1:0]     w_hdep_m1;
    logic              w_take_ok;
    logic              w_accept;
    logic [BW-1:0]     w_bd;
    logic              w_rb_ok;
    logic              w_rb_link;
    logic [31:0]       w_new_clus;

    assign w_accept   = s_axis_tvalid && (r_state == S_IDLE);
    assign w_a        = s_axis_tdata[ADDR_W-1:0];
    assign w_in_range = 32'(w_a) < 32'(TB);
    assign w_clus     = 32'(w_a) >> BW;
    assign w_rnode    = NIW'(w_clus >> OW);
    assign w_roff     = w_clus[OW-1:0];
    assign w_rdep     = r_cdep[w_rnode];
    assign w_rgrp     = GIW'(w_clus);
    assign w_rc_ok    = w_in_range && (w_a[BW-1:0] == '0) && (w_roff != '0)
                        && (w_rdep < OW'(CLUSTERS_PER_NODE - 1));
    assign w_rc_link  = !((r_nhead < NODE_NULL) && (r_nhead == NW'(w_rnode)))
                        && (w_rdep == '0);

    // Head node of the cluster list and its pop.
    assign w_hidx    = r_nhead[NIW-1:0];
    assign w_hdep    = r_cdep[w_hidx];
    assign w_hdep_m1 = w_hdep - OW'(1);
    assign w_take_ok = (r_free != '0) && (r_nhead < NODE_NULL) && (w_hdep != '0);
    assign w_new_clus = 32'(r_h) * CLUSTERS_PER_NODE + 32'(r_cs_q);

    // Block group pop and push checks.
    assign w_bd      = (r_bd_q != '0) ? r_bd_q - BW'(1) : '0;
    assign w_rb_ok   = r_ok && (r_bd_q < BW'(BLOCKS_PER_CLUSTER - 1));
    assign w_rb_link = !((r_bhead < GROUP_NULL) && (r_bhead == GW'(r_g))) && (r_bd_q == '0);

    // Memory port control.
    always_comb begin
        cs_we = 1'b0;
        cs_wa = CIW'(r_clr);
        cs_wd = ~r_clr[OW-1:0];
        cs_ra = CIW'(32'(w_hidx) * CLUSTERS_PER_NODE + 32'(w_hdep_m1));
        bs_we = 1'b0;
        bs_wa = BIW'(32'(r_g) * BLOCKS_PER_CLUSTER + 32'(r_fill));
        bs_wd = r_fill + BW'(1);
        bs_ra = BIW'(32'(r_g) * BLOCKS_PER_CLUSTER + 32'(w_bd));
        bd_we = 1'b0;
        bd_wa = r_g;
        bd_wd = w_bd;
        bd_ra = (s_axis_tuser == REQ_ALLOC_BLOCK) ? r_bhead[GIW-1:0] : w_rgrp;
        bn_we = 1'b0;
        bn_wa = r_g;
        bn_wd = GROUP_NULL;
        bn_ra = r_bhead[GIW-1:0];
        case (r_state)
            S_CLEAR: begin
                cs_we = 1'b1;
            end
            S_IDLE: begin
                if (w_accept && (s_axis_tuser == REQ_FREE_CLUSTER) && w_rc_ok) begin
                    cs_we = 1'b1;
                    cs_wa = CIW'(32'(w_rnode) * CLUSTERS_PER_NODE + 32'(w_rdep));
                    cs_wd = w_roff;
                end
            end
            S_FILL: begin
                bs_we = 1'b1;
                if (r_fill == BW'(BLOCKS_PER_CLUSTER - 2)) begin
                    bd_we = 1'b1;
                    bd_wd = BW'(BLOCKS_PER_CLUSTER - 2);
                    bn_we = 1'b1;
                end
            end
            S_BRD1: begin
                bd_we = 1'b1;
            end
            S_RBD: begin
                if (w_rb_ok) begin
                    bs_we = 1'b1;
                    bs_wa = BIW'(32'(r_g) * BLOCKS_PER_CLUSTER + 32'(r_bd_q));
                    bs_wd = r_off;
                    bd_we = 1'b1;
                    bd_wd = r_bd_q + BW'(1);
                    if (w_rb_link) begin
                        bn_we = 1'b1;
                        if (r_btail < GROUP_NULL) begin
                            bn_wa = r_btail[GIW-1:0];
                            bn_wd = GW'(r_g);
                        end
                    end
                end
            end
            S_RBLINK: begin
                bn_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Cluster stack memory.
    always_ff @(posedge i_clk) begin
        if (cs_we) begin
            m_cstk[cs_wa] <= cs_wd;
        end
        r_cs_q <= m_cstk[cs_ra];
    end

    // Block stack memory.
    always_ff @(posedge i_clk) begin
        if (bs_we) begin
            m_bstk[bs_wa] <= bs_wd;
        end
        r_bs_q <= m_bstk[bs_ra];
    end

    // Block group depth memory.
    always_ff @(posedge i_clk) begin
        if (bd_we) begin
            m_bdep[bd_wa] <= bd_wd;
        end
        r_bd_q <= m_bdep[bd_ra];
    end

    // Block group link memory.
    always_ff @(posedge i_clk) begin
        if (bn_we) begin
            m_bnext[bn_wa] <= bn_wd;
        end
        r_bn_q <= m_bnext[bn_ra];
    end

    // Sequencer, list heads and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < NODE_COUNT; i++) begin
                r_cdep[i]  <= (i == 0) ? OW'(CLUSTERS_PER_NODE - 2) : OW'(CLUSTERS_PER_NODE - 1);
                r_nnext[i] <= (i + 1 < NODE_COUNT) ? NW'(i + 1) : NODE_NULL;
            end
            r_nhead <= '0;
            r_ntail <= NW'(NODE_COUNT - 1);
            r_free  <= CW'(TC - NODE_COUNT - 1);
            r_bhead <= GROUP_NULL;
            r_btail <= GROUP_NULL;
        end else begin
            // The done state reloads the output register itself.
            if (r_o_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CW'(1);
                    if (r_clr == CW'(TC - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req <= s_axis_tuser;
                        r_ga  <= '0;
                        if ((s_axis_tuser == REQ_ALLOC_CLUSTER)
                            || ((s_axis_tuser == REQ_ALLOC_BLOCK) && (r_bhead >= GROUP_NULL))) begin
                            // Pop a cluster from the head node.
                            if (w_take_ok) begin
                                r_cdep[w_hidx] <= w_hdep_m1;
                                r_h            <= w_hidx;
                                r_free         <= r_free - CW'(1);
                                if (w_hdep_m1 == '0) begin
                                    if (r_nnext[w_hidx] >= NODE_NULL) begin
                                        r_nhead <= NODE_NULL;
                                        r_ntail <= NODE_NULL;
                                    end else begin
                                        r_nhead <= r_nnext[w_hidx];
                                    end
                                end
                                r_state <= S_CRD;
                            end else begin
                                r_st    <= ST_NOSPACE;
                                r_state <= S_DONE;
                            end
                        end else if (s_axis_tuser == REQ_ALLOC_BLOCK) begin
                            r_g     <= r_bhead[GIW-1:0];
                            r_state <= S_BRD1;
                        end else if (s_axis_tuser == REQ_FREE_CLUSTER) begin
                            // Push the cluster and rejoin the node list if it was empty.
                            if (w_rc_ok) begin
                                r_cdep[w_rnode] <= w_rdep + OW'(1);
                                r_free          <= r_free + CW'(1);
                                if (w_rc_link) begin
                                    if (r_ntail >= NODE_NULL) begin
                                        r_nhead <= NW'(w_rnode);
                                    end else begin
                                        r_nnext[r_ntail[NIW-1:0]] <= NW'(w_rnode);
                                    end
                                    r_nnext[w_rnode] <= NODE_NULL;
                                    r_ntail          <= NW'(w_rnode);
                                end
                                r_st <= ST_DONE;
                            end else begin
                                r_st <= ST_BADFREE;
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_g     <= w_rgrp;
                            r_off   <= w_a[BW-1:0];
                            r_ok    <= w_in_range && (w_a[BW-1:0] != '0)
                                       && (w_rgrp[OW-1:0] != '0);
                            r_state <= S_RBD;
                        end
                    end
                end
                S_CRD: begin
                    if (r_req == REQ_ALLOC_CLUSTER) begin
                        r_st    <= ST_DONE;
                        r_ga    <= ADDR_W'(w_new_clus * BLOCKS_PER_CLUSTER);
                        r_state <= S_DONE;
                    end else begin
                        r_g     <= GIW'(w_new_clus);
                        r_fill  <= '0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    // The fresh group hands out its highest block at once.
                    if (r_fill == BW'(BLOCKS_PER_CLUSTER - 2)) begin
                        r_st <= ST_DONE;
                        r_ga <= ADDR_W'(32'(r_g) * BLOCKS_PER_CLUSTER + BLOCKS_PER_CLUSTER - 1);
                        if (BLOCKS_PER_CLUSTER == 2) begin
                            r_bhead <= GROUP_NULL;
                            r_btail <= GROUP_NULL;
                        end else begin
                            r_bhead <= GW'(r_g);
                            r_btail <= GW'(r_g);
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_fill <= r_fill + BW'(1);
                    end
                end
                S_BRD1: begin
                    r_d     <= w_bd;
                    r_nx    <= r_bn_q;
                    r_state <= S_BRD2;
                end
                S_BRD2: begin
                    r_st <= ST_DONE;
                    r_ga <= ADDR_W'(32'(r_g) * BLOCKS_PER_CLUSTER + 32'(r_bs_q));
                    if (r_d == '0) begin
                        if (r_nx >= GROUP_NULL) begin
                            r_bhead <= GROUP_NULL;
                            r_btail <= GROUP_NULL;
                        end else begin
                            r_bhead <= r_nx;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_RBD: begin
                    r_state <= S_DONE;
                    if (w_rb_ok) begin
                        r_st <= ST_DONE;
                        if (w_rb_link) begin
                            if (r_btail >= GROUP_NULL) begin
                                r_bhead <= GW'(r_g);
                            end else begin
                                r_state <= S_RBLINK;
                            end
                            r_btail <= GW'(r_g);
                        end
                    end else begin
                        r_st <= ST_BADFREE;
                    end
                end
                S_RBLINK: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_valid || m_axis_tready) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_st;
                        r_o_addr   <= r_ga;
                        r_o_free   <= COUNT_W'(r_free);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {{(OUT_DATA_W - COUNT_W - ADDR_W){1'b0}}, r_o_free, r_o_addr};

endmodule

>>> design/cbfl_chk.sv
// Port-level checker of the allocator and its binding to the top level.
`timescale 1ns / 1ps
module cbfl_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cbfl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [cbfl_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import cbfl_pkg::*;

    // The spare status code is never produced.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != ST_UNUSED))
        else $error("unused status code on result");

    // A refused or rejected request grants nothing.
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_DONE)) |-> (m_axis_tdata[ADDR_W-1:0] == '0))
        else $error("address granted on a refused request");

    // The padding bits of a result are zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:ADDR_W+COUNT_W] == '0))
        else $error("padding bits set on result");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind cluster_and_block_free_list_allocator_unit cbfl_chk u_cbfl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
